// ===== sv/tvp_pkg.sv =====
// tvp_pkg: shared types and constants of the tlv varint payload parser
// used by tvp_parser, tvp_result_buf and tlv_varint_payload_parser
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tvp_pkg;

  // length fields: base-128, at most this many bytes, 28-bit saturating value
  localparam int MAX_LENGTH_BYTES = 4;
  localparam int LEN_W            = 28;
  localparam int VCNT_W           = 3;
  localparam int VSUM_W           = LEN_W + 7;
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
  localparam logic [LEN_W-1:0] UPD_MIN_LEN = LEN_W'(5);

  // value type byte that marks a string command
  localparam logic [7:0] VT_STRING = 8'h01;

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_TYPE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_TYPE  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_VERSION  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_ANY_CHANGE   = CFG_IDX_W'(3);

  localparam logic [7:0] CMD_TYPE_RESET = 8'd1;
  localparam logic [7:0] UPD_TYPE_RESET = 8'd2;

  // result event codes
  typedef enum logic [2:0] {
    EV_KEY   = 3'd0,
    EV_VAL   = 3'd1,
    EV_CMD   = 3'd2,
    EV_UPD   = 3'd3,
    EV_NOUPD = 3'd4,
    EV_OK    = 3'd5,
    EV_ERR   = 3'd6
  } ev_t;

  // configuration registers as seen by the parser
  typedef struct packed {
    logic [7:0]  cmd_type;
    logic [7:0]  upd_type;
    logic [31:0] own_version;
    logic        any_change;
  } tvp_cfg_t;

  // results of one byte: slot 0 main event, slot 1 command done, slot 2 end of payload
  typedef struct packed {
    logic [2:0]  valid;
    ev_t         ev_main;
    ev_t         ev_end;
    logic [7:0]  data;
    logic [31:0] version;
  } tvp_res_t;

endpackage

`default_nettype wire

// ===== sv/tlv_varint_payload_parser.sv =====
// tlv_varint_payload_parser: top level, configuration registers and channel wiring
// depends on tvp_pkg, tvp_parser, tvp_result_buf
`timescale 1ns / 1ps
`default_nettype none

// Parses a type-length-value payload arriving one byte per request, last_byte
// marking its end. A byte is registered on acceptance, parsed once the result
// buffer is free, and its zero to three results are registered in that buffer,
// which hands them out one per cycle while out_ready is high: the input takes
// one byte per cycle while each byte gives at most one result and out_ready
// stays high, and a byte that gives several results holds the input until its
// last result is taken. Configuration writes are always ready and take effect
// at once; write them only while no payload is open.
module tlv_varint_payload_parser (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // byte input
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [7:0]                     data_byte,
  input  wire logic                           last_byte,
  // results
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [2:0]                          event_res,
  output logic [7:0]                          out_byte,
  output logic [31:0]                         announced_version,
  output logic                                last_of_run,
  // configuration writes
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tvp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tvp_pkg::CFG_DATA_W-1:0] cfg_data
);

  tvp_pkg::tvp_cfg_t cfg;
  tvp_pkg::tvp_res_t res;
  logic              load;
  logic              buf_free;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cmd_type    <= tvp_pkg::CMD_TYPE_RESET;
      cfg.upd_type    <= tvp_pkg::UPD_TYPE_RESET;
      cfg.own_version <= 32'd0;
      cfg.any_change  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tvp_pkg::CFG_COMMAND_TYPE: cfg.cmd_type    <= cfg_data[7:0];
        tvp_pkg::CFG_UPDATE_TYPE:  cfg.upd_type    <= cfg_data[7:0];
        tvp_pkg::CFG_OWN_VERSION:  cfg.own_version <= cfg_data[31:0];
        tvp_pkg::CFG_ANY_CHANGE:   cfg.any_change  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // byte parser
  tvp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .buf_free  (buf_free),
    .load      (load),
    .res       (res)
  );

  // result buffer
  tvp_result_buf u_result_buf (
    .clk               (clk),
    .rst               (rst),
    .load              (load),
    .res               (res),
    .free              (buf_free),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .event_res         (event_res),
    .out_byte          (out_byte),
    .announced_version (announced_version),
    .last_of_run       (last_of_run)
  );

endmodule

`default_nettype wire

// ===== sv/tvp_result_buf.sv =====
// tvp_result_buf: holds the up to three results of one byte and hands them out in order
// depends on tvp_pkg
`timescale 1ns / 1ps
`default_nettype none

module tvp_result_buf (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire tvp_pkg::tvp_res_t res,
  output logic                  free,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [2:0]            event_res,
  output logic [7:0]            out_byte,
  output logic [31:0]           announced_version,
  output logic                  last_of_run
);

  logic [2:0]   pend;
  logic [2:0]   pend_next;
  logic [2:0]   sel;
  tvp_pkg::ev_t ev_main;
  tvp_pkg::ev_t ev_end;
  logic [7:0]   data;
  logic [31:0]  version;
  logic         pop;
  tvp_pkg::ev_t ev_shown;

  // first pending slot is the one shown
  always_comb begin
    sel = 3'b000;
    if (pend[0]) begin
      sel = 3'b001;
    end else if (pend[1]) begin
      sel = 3'b010;
    end else if (pend[2]) begin
      sel = 3'b100;
    end
  end

  assign out_valid = |pend;
  assign pop       = out_valid && out_ready;
  assign pend_next = pop ? (pend & ~sel) : pend;
  assign free      = (pend_next == 3'b000);

  // output fields
  always_comb begin
    if (sel[0]) begin
      ev_shown = ev_main;
    end else if (sel[1]) begin
      ev_shown = tvp_pkg::EV_CMD;
    end else begin
      ev_shown = ev_end;
    end
  end

  assign event_res         = ev_shown;
  assign out_byte          = sel[0] ? data : 8'd0;
  assign announced_version = sel[0] ? version : 32'd0;
  assign last_of_run       = ((pend & ~sel) == 3'b000);

  // pending slots
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 3'b000;
    end else if (load) begin
      pend <= res.valid;
    end else begin
      pend <= pend_next;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      ev_main <= res.ev_main;
      ev_end  <= res.ev_end;
      data    <= res.data;
      version <= res.version;
    end
  end

  // a new set is only taken once the previous one is fully handed out
  a_load_when_free : assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("result set loaded over pending results");

  // the final result of a run leaves the buffer empty unless a new set arrives
  a_run_end_empties : assert property (@(posedge clk) disable iff (rst)
    pop && last_of_run && !load |=> !out_valid)
    else $error("results left after last of run");

  // payload fields are zero outside the main slot
  a_fields_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && !sel[0] |-> out_byte == 8'd0 && announced_version == 32'd0)
    else $error("payload field set on a non-data event");

endmodule

`default_nettype wire

// ===== sv/tvp_parser.sv =====
// tvp_parser: input register, parse state and the per-byte step logic
// depends on tvp_pkg
`timescale 1ns / 1ps
`default_nettype none

module tvp_parser (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tvp_pkg::tvp_cfg_t cfg,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        data_byte,
  input  wire logic              last_byte,
  input  wire logic              buf_free,
  output logic                   load,
  output tvp_pkg::tvp_res_t      res
);

  typedef enum logic [3:0] {
    PH_HDR, PH_HLEN, PH_TYPE, PH_MLEN, PH_SKIP, PH_CVT, PH_CKLEN,
    PH_CKEY, PH_CVAL, PH_UPD0, PH_UPDV, PH_WAIT
  } phase_t;

  // input register
  logic       q_valid;
  logic [7:0] q_byte;
  logic       q_last;
  logic       proc;

  // parse state
  phase_t                       phase, phase_next;
  logic [tvp_pkg::LEN_W-1:0]    vacc, vacc_next;
  logic [tvp_pkg::VCNT_W-1:0]   vcnt, vcnt_next;
  logic [7:0]                   cur_type, cur_type_next;
  logic [tvp_pkg::LEN_W-1:0]    body_left, body_left_next;
  logic [tvp_pkg::LEN_W-1:0]    key_left, key_left_next;
  logic                         is_str, is_str_next;
  logic [31:0]                  ver_acc, ver_acc_next;
  logic [1:0]                   seen, seen_next;

  // step helpers
  logic [tvp_pkg::LEN_W-1:0]    bl_dec;
  logic [tvp_pkg::LEN_W-1:0]    kl_dec;
  logic [5:0]                   vshamt;
  logic [tvp_pkg::VSUM_W-1:0]   vsum;
  logic [tvp_pkg::LEN_W-1:0]    vacc_new;
  logic [tvp_pkg::VCNT_W-1:0]   vcnt_inc;
  logic                         vdone;
  logic                         vlong;
  logic [31:0]                  ver_new;
  logic                         want;

  assign proc     = q_valid && buf_free;
  assign in_ready = !q_valid || proc;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      q_valid <= 1'b1;
    end else if (proc) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_byte <= data_byte;
      q_last <= last_byte;
    end
  end

  // base-128 length feed, saturating at 28 bits
  assign bl_dec   = (body_left != '0) ? body_left - tvp_pkg::LEN_W'(1) : body_left;
  assign kl_dec   = (key_left != '0) ? key_left - tvp_pkg::LEN_W'(1) : key_left;
  assign vshamt   = 6'(vcnt) * 6'd7;
  assign vsum     = {7'd0, vacc} | (tvp_pkg::VSUM_W'(q_byte[6:0]) << vshamt);
  assign vacc_new = (|vsum[tvp_pkg::VSUM_W-1:tvp_pkg::LEN_W]) ? tvp_pkg::LEN_MAX
                                                              : vsum[tvp_pkg::LEN_W-1:0];
  assign vcnt_inc = vcnt + tvp_pkg::VCNT_W'(1);
  assign vdone    = !q_byte[7];
  assign vlong    = q_byte[7] && (vcnt_inc >= tvp_pkg::VCNT_W'(tvp_pkg::MAX_LENGTH_BYTES));

  // version shift and compare
  assign ver_new = {ver_acc[23:0], q_byte};
  assign want    = cfg.any_change ? (ver_new != cfg.own_version)
                                  : (ver_new > cfg.own_version);

  // one parse step per byte
  always_comb begin
    phase_next     = phase;
    vacc_next      = vacc;
    vcnt_next      = vcnt;
    cur_type_next  = cur_type;
    body_left_next = body_left;
    key_left_next  = key_left;
    is_str_next    = is_str;
    ver_acc_next   = ver_acc;
    seen_next      = seen;
    res.valid      = 3'b000;
    res.ev_main    = tvp_pkg::EV_ERR;
    res.ev_end     = tvp_pkg::EV_OK;
    res.data       = 8'd0;
    res.version    = 32'd0;

    if (proc) begin
      case (phase)
        PH_HDR: begin
          if (q_byte[7:4] != 4'd1) begin
            res.valid[0] = 1'b1;
            phase_next   = PH_WAIT;
          end else begin
            vacc_next  = '0;
            vcnt_next  = '0;
            phase_next = PH_HLEN;
          end
        end
        PH_HLEN: begin
          vacc_next = vacc_new;
          vcnt_next = vcnt_inc;
          if (vdone) begin
            phase_next = PH_TYPE;
          end else if (vlong) begin
            res.valid[0] = 1'b1;
            phase_next   = PH_WAIT;
          end
        end
        PH_TYPE: begin
          cur_type_next = q_byte;
          vacc_next     = '0;
          vcnt_next     = '0;
          phase_next    = PH_MLEN;
        end
        PH_MLEN: begin
          vacc_next = vacc_new;
          vcnt_next = vcnt_inc;
          if (vdone) begin
            // start of the message body
            body_left_next = vacc_new;
            if (cur_type == cfg.cmd_type) begin
              phase_next = (vacc_new != '0) ? PH_CVT : PH_TYPE;
            end else if (cur_type == cfg.upd_type && vacc_new >= tvp_pkg::UPD_MIN_LEN) begin
              phase_next = PH_UPD0;
            end else begin
              phase_next = (vacc_new != '0) ? PH_SKIP : PH_TYPE;
            end
          end else if (vlong) begin
            res.valid[0] = 1'b1;
            phase_next   = PH_WAIT;
          end
        end
        PH_SKIP: begin
          body_left_next = bl_dec;
          if (bl_dec == '0) begin
            phase_next = PH_TYPE;
          end
        end
        PH_CVT: begin
          body_left_next = bl_dec;
          is_str_next    = (q_byte == tvp_pkg::VT_STRING);
          if (bl_dec == '0) begin
            phase_next = PH_TYPE;
          end else begin
            vacc_next  = '0;
            vcnt_next  = '0;
            phase_next = PH_CKLEN;
          end
        end
        PH_CKLEN: begin
          body_left_next = bl_dec;
          vacc_next      = vacc_new;
          vcnt_next      = vcnt_inc;
          if (vdone) begin
            if (vacc_new > bl_dec) begin
              phase_next = (bl_dec != '0) ? PH_SKIP : PH_TYPE;
            end else begin
              key_left_next = vacc_new;
              if (vacc_new != '0) begin
                phase_next = PH_CKEY;
              end else if (bl_dec != '0) begin
                phase_next = PH_CVAL;
              end else begin
                res.valid[1] = is_str;
                phase_next   = PH_TYPE;
              end
            end
          end else if (vlong) begin
            phase_next = (bl_dec != '0) ? PH_SKIP : PH_TYPE;
          end else if (bl_dec == '0) begin
            phase_next = PH_TYPE;
          end
        end
        PH_CKEY: begin
          body_left_next = bl_dec;
          key_left_next  = kl_dec;
          res.valid[0]   = is_str;
          res.ev_main    = tvp_pkg::EV_KEY;
          res.data       = q_byte;
          if (kl_dec == '0) begin
            if (bl_dec != '0) begin
              phase_next = PH_CVAL;
            end else begin
              res.valid[1] = is_str;
              phase_next   = PH_TYPE;
            end
          end
        end
        PH_CVAL: begin
          body_left_next = bl_dec;
          res.valid[0]   = is_str;
          res.ev_main    = tvp_pkg::EV_VAL;
          res.data       = q_byte;
          if (bl_dec == '0) begin
            res.valid[1] = is_str;
            phase_next   = PH_TYPE;
          end
        end
        PH_UPD0: begin
          body_left_next = bl_dec;
          ver_acc_next   = 32'd0;
          seen_next      = 2'd0;
          phase_next     = PH_UPDV;
        end
        PH_UPDV: begin
          body_left_next = bl_dec;
          ver_acc_next   = ver_new;
          if (seen == 2'd3) begin
            res.valid[0] = 1'b1;
            res.ev_main  = want ? tvp_pkg::EV_UPD : tvp_pkg::EV_NOUPD;
            res.version  = ver_new;
            phase_next   = PH_WAIT;
          end else begin
            seen_next = seen + 2'd1;
          end
        end
        default: begin
          phase_next = PH_WAIT;
        end
      endcase

      // end of payload: report and return to the header
      if (q_last) begin
        if (phase_next == PH_TYPE) begin
          res.valid[2] = 1'b1;
          res.ev_end   = tvp_pkg::EV_OK;
        end else if (phase_next != PH_WAIT) begin
          res.valid[2] = 1'b1;
          res.ev_end   = tvp_pkg::EV_ERR;
        end
        phase_next     = PH_HDR;
        vacc_next      = '0;
        vcnt_next      = '0;
        cur_type_next  = 8'd0;
        body_left_next = '0;
        key_left_next  = '0;
        is_str_next    = 1'b0;
        ver_acc_next   = 32'd0;
        seen_next      = 2'd0;
      end
    end
  end

  assign load = proc && (res.valid != 3'b000);

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HDR;
      vacc      <= '0;
      vcnt      <= '0;
      cur_type  <= 8'd0;
      body_left <= '0;
      key_left  <= '0;
      is_str    <= 1'b0;
      ver_acc   <= 32'd0;
      seen      <= 2'd0;
    end else begin
      phase     <= phase_next;
      vacc      <= vacc_next;
      vcnt      <= vcnt_next;
      cur_type  <= cur_type_next;
      body_left <= body_left_next;
      key_left  <= key_left_next;
      is_str    <= is_str_next;
      ver_acc   <= ver_acc_next;
      seen      <= seen_next;
    end
  end

  // the last byte of a payload always returns the parser to the header
  a_last_to_hdr : assert property (@(posedge clk) disable iff (rst)
    proc && q_last |=> phase == PH_HDR)
    else $error("parser not back at header after last byte");

  // key bytes never outrun the body
  a_key_in_body : assert property (@(posedge clk) disable iff (rst)
    phase == PH_CKEY |-> key_left != '0 && key_left <= body_left)
    else $error("key count inconsistent with body count");

  // body phases are only entered with bytes left
  a_body_left : assert property (@(posedge clk) disable iff (rst)
    phase == PH_SKIP || phase == PH_CVAL || phase == PH_UPDV |-> body_left != '0)
    else $error("body phase with no body bytes left");

endmodule

`default_nettype wire

// ===== sim/tb_tlv_varint_payload_parser.sv =====
// tb_tlv_varint_payload_parser: self-checking testbench of the tlv varint payload parser
// drives byte requests and register writes, predicts every result and checks it in order
// depends on tvp_pkg and tlv_varint_payload_parser
`timescale 1ns / 1ps

module tb_tlv_varint_payload_parser;
  import tvp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 200;
  localparam int PHASE_BYTES = 30;
  localparam int NUM_SETTINGS = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = CFG_IDX_W'(8'hFC);

  // parser states of the predictor
  typedef enum logic [3:0] {
    P_HEADER, P_HDR_LEN, P_MSG_TYPE, P_MSG_LEN, P_SKIP_BODY, P_CMD_VTYPE, P_CMD_KLEN,
    P_CMD_KEY, P_CMD_VALUE, P_UPD_FIRST, P_UPD_VERSION, P_DRAIN
  } parse_state_e;

  typedef struct {
    ev_t         ev;
    logic [7:0]  data;
    logic [31:0] version;
    logic        last;
  } parser_event_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } byte_req_t;

  // dut signals
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            data_byte = 8'h00;
  logic                  last_byte = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [2:0]            event_res;
  logic [7:0]            out_byte;
  logic [31:0]           announced_version;
  logic                  last_of_run;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // register copies
  logic [7:0]  cmd_code   = CMD_TYPE_RESET;
  logic [7:0]  upd_code   = UPD_TYPE_RESET;
  logic [31:0] own_ver    = 32'd0;
  logic        any_change = 1'b0;

  // predictor state
  parse_state_e parse_state = P_HEADER;
  logic [27:0]  len_acc = '0;
  logic [2:0]   len_cnt = '0;
  logic [7:0]   msg_type = '0;
  logic [27:0]  body_left = '0;
  logic [27:0]  key_left = '0;
  logic         is_string = 1'b0;
  logic [31:0]  ver_acc = '0;
  logic [1:0]   ver_cnt = '0;

  parser_event_t expected_events[$];
  parser_event_t step_events[$];
  byte_req_t     byte_requests[$];
  byte_req_t     next_req;
  logic [7:0]    payload_bytes[$];

  // run control and bookkeeping
  bit send_gaps = 1'b1;
  bit recv_stalls = 1'b1;
  int send_gap_left = 0;
  int stall_left = 0;
  int stall_draw = 0;
  int long_hold_left = 0;
  int holds_requested = 0;
  int holds_served = 0;
  int cycle_count = 0;
  int mismatch_count = 0;
  int results_checked = 0;
  int bytes_accepted = 0;
  int bytes_queued = 0;
  int payload_count = 0;
  int settings_used = 1;
  int event_tally [0:7];

  tlv_varint_payload_parser u_top (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .data_byte         (data_byte),
    .last_byte         (last_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .event_res         (event_res),
    .out_byte          (out_byte),
    .announced_version (announced_version),
    .last_of_run       (last_of_run),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[tlv_varint_payload_parser] ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------- predictor

  task automatic reset_parser();
    parse_state = P_HEADER;
    len_acc = '0;
    len_cnt = '0;
    msg_type = '0;
    body_left = '0;
    key_left = '0;
    is_string = 1'b0;
    ver_acc = '0;
    ver_cnt = '0;
  endtask

  task automatic add_event(input ev_t code, input logic [7:0] b, input logic [31:0] ver);
    parser_event_t e;
    e.ev = code;
    e.data = b;
    e.version = ver;
    e.last = 1'b0;
    step_events.push_back(e);
  endtask

  task automatic start_length();
    len_acc = '0;
    len_cnt = '0;
  endtask

  // one base-128 length byte: 1 done, 0 more to come, -1 too long
  task automatic feed_length(input logic [7:0] b, output int status);
    logic [63:0] sum;
    sum = {36'd0, len_acc} | (64'(b & 8'h7f) << (7 * len_cnt));
    if (sum > 64'h0FFF_FFFF) sum = 64'h0FFF_FFFF;
    len_acc = sum[27:0];
    len_cnt = len_cnt + 3'd1;
    if (!b[7]) status = 1;
    else if (len_cnt >= MAX_LENGTH_BYTES) status = -1;
    else status = 0;
  endtask

  task automatic count_body();
    if (body_left != 0) body_left = body_left - 28'd1;
  endtask

  task automatic skip_body();
    parse_state = (body_left != 0) ? P_SKIP_BODY : P_MSG_TYPE;
  endtask

  task automatic finish_command();
    if (is_string) add_event(EV_CMD, 8'h00, 32'd0);
    parse_state = P_MSG_TYPE;
  endtask

  // work out the results of one accepted byte request
  task automatic parse_byte(input logic [7:0] b, input logic last);
    int  r;
    bit  newer;
    step_events.delete();
    case (parse_state)
      P_HEADER: begin
        if (b[7:4] != 4'h1) begin
          add_event(EV_ERR, 8'h00, 32'd0);
          parse_state = P_DRAIN;
        end else begin
          start_length();
          parse_state = P_HDR_LEN;
        end
      end
      P_HDR_LEN: begin
        feed_length(b, r);
        if (r < 0) begin
          add_event(EV_ERR, 8'h00, 32'd0);
          parse_state = P_DRAIN;
        end else if (r > 0) begin
          parse_state = P_MSG_TYPE;
        end
      end
      P_MSG_TYPE: begin
        msg_type = b;
        start_length();
        parse_state = P_MSG_LEN;
      end
      P_MSG_LEN: begin
        feed_length(b, r);
        if (r < 0) begin
          add_event(EV_ERR, 8'h00, 32'd0);
          parse_state = P_DRAIN;
        end else if (r > 0) begin
          // length complete: pick the body handler, command wins on equal codes
          body_left = len_acc;
          if (msg_type == cmd_code) parse_state = (len_acc != 0) ? P_CMD_VTYPE : P_MSG_TYPE;
          else if (msg_type == upd_code && len_acc >= UPD_MIN_LEN) parse_state = P_UPD_FIRST;
          else skip_body();
        end
      end
      P_SKIP_BODY: begin
        count_body();
        if (body_left == 0) parse_state = P_MSG_TYPE;
      end
      P_CMD_VTYPE: begin
        count_body();
        is_string = (b == VT_STRING);
        if (body_left == 0) begin
          parse_state = P_MSG_TYPE;
        end else begin
          start_length();
          parse_state = P_CMD_KLEN;
        end
      end
      P_CMD_KLEN: begin
        count_body();
        feed_length(b, r);
        if (r < 0) begin
          skip_body();
        end else if (r == 0) begin
          if (body_left == 0) parse_state = P_MSG_TYPE;
        end else if (len_acc > body_left) begin
          skip_body();
        end else begin
          key_left = len_acc;
          if (key_left != 0) parse_state = P_CMD_KEY;
          else if (body_left != 0) parse_state = P_CMD_VALUE;
          else finish_command();
        end
      end
      P_CMD_KEY: begin
        count_body();
        if (key_left != 0) key_left = key_left - 28'd1;
        if (is_string) add_event(EV_KEY, b, 32'd0);
        if (key_left == 0) begin
          if (body_left != 0) parse_state = P_CMD_VALUE;
          else finish_command();
        end
      end
      P_CMD_VALUE: begin
        count_body();
        if (is_string) add_event(EV_VAL, b, 32'd0);
        if (body_left == 0) finish_command();
      end
      P_UPD_FIRST: begin
        count_body();
        ver_acc = '0;
        ver_cnt = '0;
        parse_state = P_UPD_VERSION;
      end
      P_UPD_VERSION: begin
        count_body();
        ver_acc = {ver_acc[23:0], b};
        if (ver_cnt >= 2'd3) begin
          newer = any_change ? (ver_acc != own_ver) : (ver_acc > own_ver);
          add_event(newer ? EV_UPD : EV_NOUPD, 8'h00, ver_acc);
          parse_state = P_DRAIN;
        end else begin
          ver_cnt = ver_cnt + 2'd1;
        end
      end
      default: parse_state = P_DRAIN;
    endcase

    // end of payload
    if (last) begin
      if (parse_state == P_MSG_TYPE) add_event(EV_OK, 8'h00, 32'd0);
      else if (parse_state != P_DRAIN) add_event(EV_ERR, 8'h00, 32'd0);
      reset_parser();
    end

    if (step_events.size() > 0) step_events[step_events.size() - 1].last = 1'b1;
    foreach (step_events[i]) expected_events.push_back(step_events[i]);
  endtask

  // ---------------------------------------------------------------- byte driver

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap_left <= 0;
      reset_parser();
    end else begin
      if (in_valid && in_ready) begin
        parse_byte(data_byte, last_byte);
        bytes_accepted++;
      end
      // present the next request once the current one is gone
      if (!in_valid || in_ready) begin
        if (send_gap_left > 0) begin
          in_valid <= 1'b0;
          send_gap_left <= send_gap_left - 1;
        end else if (byte_requests.size() > 0) begin
          next_req = byte_requests.pop_front();
          in_valid <= 1'b1;
          data_byte <= next_req.data;
          last_byte <= next_req.last;
          send_gap_left <= send_gaps ? int'($urandom_range(0, 5)) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- result monitor

  task automatic compare_result();
    parser_event_t oldest;
    results_checked++;
    event_tally[event_res]++;
    if (expected_events.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected: event %0d byte %02h",
                                event_res, out_byte));
      return;
    end
    oldest = expected_events.pop_front();
    if (event_res != oldest.ev)
      report_mismatch($sformatf("event %0d, expected %0d", event_res, oldest.ev));
    if (out_byte != oldest.data)
      report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, oldest.data));
    if (announced_version != oldest.version)
      report_mismatch($sformatf("announced_version %08h, expected %08h",
                                announced_version, oldest.version));
    if (last_of_run != oldest.last)
      report_mismatch($sformatf("last_of_run %0b, expected %0b", last_of_run, oldest.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
      long_hold_left <= 0;
    end else begin
      if (out_valid && out_ready) compare_result();
      // long hold-off first, then a short random stall after each result taken
      if (long_hold_left > 0) begin
        out_ready <= 1'b0;
        long_hold_left <= long_hold_left - 1;
      end else if (holds_served != holds_requested) begin
        out_ready <= 1'b0;
        long_hold_left <= LONG_HOLD;
        holds_served <= holds_served + 1;
      end else if (out_valid && out_ready) begin
        stall_draw = recv_stalls ? int'($urandom_range(0, 5)) : 0;
        out_ready <= (stall_draw == 0);
        stall_left <= (stall_draw > 0) ? stall_draw - 1 : 0;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- register writes

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_COMMAND_TYPE: cmd_code = val[7:0];
      CFG_UPDATE_TYPE:  upd_code = val[7:0];
      CFG_OWN_VERSION:  own_ver = val;
      CFG_ANY_CHANGE:   any_change = val[0];
      default: ;
    endcase
  endtask

  // upper bits carry junk that the block must drop
  task automatic set_registers(input logic [7:0] cmd, input logic [7:0] upd,
                               input logic [31:0] own, input logic any);
    write_reg(CFG_COMMAND_TYPE, {24'($urandom), cmd});
    write_reg(CFG_UPDATE_TYPE, {24'($urandom), upd});
    write_reg(CFG_OWN_VERSION, own);
    write_reg(CFG_ANY_CHANGE, {31'($urandom), any});
    write_reg(CFG_UNUSED_INDEX, $urandom);
    settings_used++;
  endtask

  // wait until every byte is in, every result out and the pipeline quiet
  task automatic wait_idle();
    while (bytes_accepted != bytes_queued || expected_events.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- payload builder

  // base-128 little-endian, padded with continuation groups up to nbytes
  task automatic put_length(ref logic [7:0] q[$], input int unsigned value, input int nbytes);
    int         cnt;
    logic [7:0] g;
    cnt = 0;
    do begin
      g = 8'(value & 32'h7f);
      value = value >> 7;
      cnt++;
      if (value != 0 || cnt < nbytes) g = g | 8'h80;
      q.push_back(g);
    end while (value != 0 || cnt < nbytes);
  endtask

  task automatic put_message(output bit stopped);
    logic [7:0]  body[$];
    logic [7:0]  mtype;
    logic [7:0]  vt;
    logic [31:0] ver;
    int          pick;
    int          klen;
    int          rest;
    stopped = 1'b0;
    mtype = cmd_code;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      // string command
      body.push_back(VT_STRING);
      klen = $urandom_range(0, 4);
      put_length(body, klen, $urandom_range(0, 2));
      repeat (klen + $urandom_range(0, 4)) body.push_back(8'($urandom));
    end else if (pick < 50) begin
      // command with another value type
      do vt = 8'($urandom); while (vt == VT_STRING);
      body.push_back(vt);
      if ($urandom_range(0, 2) != 0) begin
        klen = $urandom_range(0, 3);
        put_length(body, klen, 0);
        repeat (klen + $urandom_range(0, 3)) body.push_back(8'($urandom));
      end
    end else if (pick < 62) begin
      // inconsistent command
      body.push_back(($urandom_range(0, 1) != 0) ? VT_STRING : 8'($urandom));
      case ($urandom_range(0, 3))
        0: body.delete();
        1: begin
          rest = $urandom_range(0, 3);
          put_length(body, rest + 1 + $urandom_range(0, 2), 0);
          repeat (rest) body.push_back(8'($urandom));
        end
        2: begin
          put_length(body, $urandom_range(0, 3), 5);
          repeat ($urandom_range(0, 2)) body.push_back(8'($urandom));
        end
        default: body.push_back(8'h80 | 8'($urandom));
      endcase
    end else if (pick < 74) begin
      // update announcement, rest of payload is ignored
      mtype = upd_code;
      case ($urandom_range(0, 5))
        0: ver = own_ver;
        1: ver = own_ver + 32'd1;
        2: ver = own_ver - 32'd1;
        3: ver = 32'd0;
        4: ver = 32'hFFFF_FFFF;
        default: ver = $urandom;
      endcase
      body.push_back(8'($urandom));
      body.push_back(ver[31:24]);
      body.push_back(ver[23:16]);
      body.push_back(ver[15:8]);
      body.push_back(ver[7:0]);
      repeat ($urandom_range(0, 2)) body.push_back(8'($urandom));
      stopped = 1'b1;
    end else if (pick < 80) begin
      // update too short to hold a version
      mtype = upd_code;
      repeat ($urandom_range(0, 4)) body.push_back(8'($urandom));
    end else if (pick < 92) begin
      // unknown type
      do mtype = 8'($urandom); while (mtype == cmd_code || mtype == upd_code);
      repeat ($urandom_range(0, 5)) body.push_back(8'($urandom));
    end else if (pick < 96) begin
      // huge length, payload ends inside the body
      payload_bytes.push_back(8'($urandom));
      put_length(payload_bytes, 32'h0FFF_FFFF, 0);
      repeat ($urandom_range(0, 3)) payload_bytes.push_back(8'($urandom));
      return;
    end else begin
      // length field that keeps going
      payload_bytes.push_back(8'($urandom));
      put_length(payload_bytes, $urandom_range(0, 5), $urandom_range(5, 6));
      return;
    end
    payload_bytes.push_back(mtype);
    put_length(payload_bytes, body.size(), ($urandom_range(0, 9) == 0) ? 2 : 0);
    foreach (body[i]) payload_bytes.push_back(body[i]);
  endtask

  task automatic build_payload();
    int nmsg;
    bit stopped;
    payload_bytes.delete();
    // plain noise
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 5)) payload_bytes.push_back(8'($urandom));
      return;
    end
    // header byte and header length
    if ($urandom_range(0, 11) == 0) payload_bytes.push_back(8'($urandom));
    else payload_bytes.push_back({4'h1, 4'($urandom)});
    if ($urandom_range(0, 19) == 0) put_length(payload_bytes, 0, 6);
    else put_length(payload_bytes, $urandom_range(0, 300), $urandom_range(0, 3));
    nmsg = $urandom_range(0, 3);
    stopped = 1'b0;
    for (int k = 0; k < nmsg && !stopped; k++) put_message(stopped);
    if (stopped) repeat ($urandom_range(0, 3)) payload_bytes.push_back(8'($urandom));
    // cut the payload short now and then
    if (payload_bytes.size() > 1 && $urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 3))
        if (payload_bytes.size() > 1) void'(payload_bytes.pop_back());
  endtask

  task automatic queue_payload();
    byte_req_t r;
    foreach (payload_bytes[i]) begin
      r.data = payload_bytes[i];
      r.last = (i == payload_bytes.size() - 1);
      byte_requests.push_back(r);
    end
    bytes_queued += payload_bytes.size();
    payload_count++;
  endtask

  // ---------------------------------------------------------------- test sequence

  initial begin
    int         phase_start;
    int         settle;
    logic [7:0] shared_code;
    foreach (event_tally[i]) event_tally[i] = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed payloads at reset register values
    payload_bytes = '{8'h1F};
    queue_payload();
    payload_bytes = '{8'h20, 8'h00};
    queue_payload();
    payload_bytes = '{8'h10, 8'h00, 8'h01, 8'h05, 8'h01, 8'h01, 8'hAB, 8'hFF, 8'h00};
    queue_payload();
    payload_bytes = '{8'h1F, 8'h00, 8'h02, 8'h05, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h77};
    queue_payload();
    payload_bytes = '{8'h11, 8'h00, 8'h02, 8'h05, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00};
    queue_payload();

    // random payloads under several register settings
    for (int setting = 0; setting < NUM_SETTINGS; setting++) begin
      wait_idle();
      case (setting)
        0: set_registers(8'h00, 8'hFF, 32'h0000_0000, 1'b0);
        1: set_registers(8'hFF, 8'h00, 32'hFFFF_FFFF, 1'b1);
        2: begin
          shared_code = 8'($urandom);
          set_registers(shared_code, shared_code, $urandom, 1'b0);
        end
        3: set_registers(8'($urandom), 8'($urandom), $urandom, 1'b1);
        default: set_registers(CMD_TYPE_RESET, UPD_TYPE_RESET, 32'h8000_0000, 1'b0);
      endcase
      send_gaps = !(setting == 0 || setting == 2);
      recv_stalls = (setting != 0);
      // receiver holds off while the sender keeps pushing
      if (setting == 2) holds_requested++;
      phase_start = bytes_queued;
      while (bytes_queued - phase_start < PHASE_BYTES) begin
        build_payload();
        queue_payload();
      end
    end

    // drain and settle
    while (bytes_accepted != bytes_queued) @(posedge clk);
    settle = 0;
    while (expected_events.size() != 0 && settle < 5000) begin
      @(posedge clk);
      settle++;
    end
    repeat (20) @(posedge clk);
    if (expected_events.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", expected_events.size()));

    $display("covered %0d bytes in %0d payloads under %0d register settings, %0d results checked",
             bytes_accepted, payload_count, settings_used, results_checked);
    $display("results: %0d ok, %0d error, %0d update, %0d no update, %0d command done",
             event_tally[EV_OK], event_tally[EV_ERR], event_tally[EV_UPD],
             event_tally[EV_NOUPD], event_tally[EV_CMD]);
    if (mismatch_count == 0) begin
      $display("[tlv_varint_payload_parser] OK");
    end else begin
      $display("[tlv_varint_payload_parser] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/tvp_pkg.sv
sv/tvp_result_buf.sv
sv/tvp_parser.sv
sv/tlv_varint_payload_parser.sv
sim/tb_tlv_varint_payload_parser.sv
